// ===== hw/rtl/fuss_pkg.sv =====
package fuss_pkg;

  localparam int unsigned SYM_W = 8;

  typedef enum logic [1:0] {
    OP_IGNORE,
    OP_FIRST,
    OP_REPEAT
  } op_kind_e;

  typedef struct packed {
    op_kind_e         kind;
    logic [SYM_W-1:0] sym;
  } fuss_op_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_POP,
    B_RDC,
    B_RDD,
    B_CHK,
    B_EMIT
  } back_state_e;

endpackage

// ===== hw/rtl/fuss_ram.sv =====
module fuss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/fuss_front.sv =====
module fuss_front #(
  parameter int unsigned ALPHABET_SIZE = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [fuss_pkg::SYM_W-1:0]        symbol_i,
  input  logic                              full_i,
  output logic                              push_o,
  output fuss_pkg::fuss_op_t                op_o
);
  import fuss_pkg::*;

  localparam int unsigned IDX_W = $clog2(ALPHABET_SIZE);

  // one seen bit per symbol: count >= 1
  logic [ALPHABET_SIZE-1:0] seen_q, seen_d;
  logic                     in_range;
  logic [IDX_W-1:0]         idx;
  logic                     accept;

  assign in_range   = {1'b0, symbol_i} < (SYM_W + 1)'(ALPHABET_SIZE);
  assign idx        = symbol_i[IDX_W-1:0];
  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & ~full_i;
  assign push_o     = accept;

  always_comb begin
    op_o.sym = symbol_i;
    if (!in_range) begin
      op_o.kind = OP_IGNORE;
    end else if (seen_q[idx]) begin
      op_o.kind = OP_REPEAT;
    end else begin
      op_o.kind = OP_FIRST;
    end
    seen_d = seen_q;
    if (accept && op_o.kind == OP_FIRST) begin
      seen_d[idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else begin
      seen_q <= seen_d;
    end
  end

endmodule

// ===== hw/rtl/fuss_queue.sv =====
module fuss_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fuss_pkg::fuss_op_t op_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output fuss_pkg::fuss_op_t op_o
);
  import fuss_pkg::*;

  fuss_op_t   entry_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign op_o    = entry_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/fuss_back.sv =====
module fuss_back #(
  parameter int unsigned ALPHABET_SIZE = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  fuss_pkg::fuss_op_t         q_op_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       found_o,
  output logic [fuss_pkg::SYM_W-1:0] first_unique_o
);
  import fuss_pkg::*;

  localparam int unsigned IDX_W  = $clog2(ALPHABET_SIZE);
  localparam int unsigned FILL_W = $clog2(ALPHABET_SIZE + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALPHABET_SIZE - 1);

  back_state_e       state_q, state_d;
  logic [IDX_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [SYM_W-1:0]  head_sym_q, head_sym_d;
  logic              out_valid_q, out_valid_d;
  logic              found_q, found_d;
  logic [SYM_W-1:0]  first_q, first_d;

  logic              cand_we;
  logic [SYM_W-1:0]  cand_rdata;
  logic              dup_we, dup_wdata;
  logic              dup_rdata;

  // candidate FIFO storage
  fuss_ram #(
    .WIDTH (SYM_W),
    .DEPTH (ALPHABET_SIZE)
  ) u_cand_ram (
    .clk_i   (clk_i),
    .we_i    (cand_we),
    .waddr_i (tail_q),
    .wdata_i (q_op_i.sym),
    .raddr_i (head_q),
    .rdata_o (cand_rdata)
  );

  // repeated flag per symbol: valid once the symbol has been seen
  fuss_ram #(
    .WIDTH (1),
    .DEPTH (ALPHABET_SIZE)
  ) u_dup_ram (
    .clk_i   (clk_i),
    .we_i    (dup_we),
    .waddr_i (q_op_i.sym[IDX_W-1:0]),
    .wdata_i (dup_wdata),
    .raddr_i (cand_rdata[IDX_W-1:0]),
    .rdata_o (dup_rdata)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    head_sym_d  = head_sym_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    found_d     = found_q;
    first_d     = first_q;
    cand_we     = 1'b0;
    dup_we      = 1'b0;
    dup_wdata   = 1'b0;
    q_pop_o     = 1'b0;

    case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_op_i.kind)
            OP_FIRST: begin
              cand_we = 1'b1;
              dup_we  = 1'b1;
              tail_d  = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
              fill_d  = fill_q + 1'b1;
              if (fill_q == '0) begin
                head_sym_d = q_op_i.sym;
              end
              state_d = B_EMIT;
            end
            OP_REPEAT: begin
              dup_we    = 1'b1;
              dup_wdata = 1'b1;
              // only a repeat of the current head can expose dropped heads
              if (fill_q != '0 && head_sym_q == q_op_i.sym) begin
                state_d = B_POP;
              end else begin
                state_d = B_EMIT;
              end
            end
            default: begin
              state_d = B_EMIT;
            end
          endcase
        end
      end
      B_POP: begin
        head_d = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
        fill_d = fill_q - 1'b1;
        if (fill_q == FILL_W'(1)) begin
          state_d = B_EMIT;
        end else begin
          state_d = B_RDC;
        end
      end
      B_RDC: begin
        state_d = B_RDD;
      end
      B_RDD: begin
        head_sym_d = cand_rdata;
        state_d    = B_CHK;
      end
      B_CHK: begin
        state_d = dup_rdata ? B_POP : B_EMIT;
      end
      B_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          found_d     = (fill_q != '0);
          first_d     = (fill_q != '0) ? head_sym_q : '0;
          state_d     = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_sym_q <= head_sym_d;
    found_q    <= found_d;
    first_q    <= first_d;
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign first_unique_o = first_q;

endmodule

// ===== hw/rtl/first_unique_symbol_stream.sv =====
// First non-repeating symbol of a byte stream.
// Input channel: in_valid_i / in_ready_o with symbol_i, one byte per word.
// Output channel: out_valid_o / out_ready_i with found_o and first_unique_o,
// exactly one word per input word, in order. found_o is 0 and first_unique_o
// is 0 while no symbol has been seen exactly once.
// Symbols at or above ALPHABET_SIZE leave the state alone and repeat the
// current answer.
// The front side classifies each word against per-symbol seen bits and
// pushes it into a two-entry queue; in_ready_o drops only when that queue is
// full. The back side updates the candidate FIFO and repeat flags (two RAMs)
// and holds the result in an output register.
// Each word is registered in the queue, then popped by the back side, which
// updates the FIFO and emits one output word; each dropped FIFO head adds a
// pop, RAM read, data capture and repeat check (each symbol is dropped at
// most once). The back side takes the next word only after emitting the last.
// Reset clears the seen bits, FIFO pointers and all valid flags; no clearing
// pass is needed. A stalled receiver holds the output word; the back side
// then waits and the queue fills, after which in_ready_o goes low.
module first_unique_symbol_stream #(
  parameter int unsigned ALPHABET_SIZE = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] symbol_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       found_o,
  output logic [7:0] first_unique_o
);
  import fuss_pkg::*;

  logic     push, q_full, q_valid, q_pop;
  fuss_op_t push_op, q_op;

  fuss_front #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .symbol_i   (symbol_i),
    .full_i     (q_full),
    .push_o     (push),
    .op_o       (push_op)
  );

  fuss_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .op_o    (q_op)
  );

  fuss_back #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_op_i         (q_op),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .first_unique_o (first_unique_o)
  );

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (first_unique_o == 8'd0))
    else $error("first_unique_o nonzero while found_o is low");

  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("back side popped an empty queue");

  a_out_of_range_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && ({1'b0, symbol_i} >= 9'(ALPHABET_SIZE))) |-> (push_op.kind == OP_IGNORE))
    else $error("symbol outside the alphabet was not marked ignored");

endmodule
